// ===== sv/tasp_pkg.sv =====
// Shared types and constants for the two-axis stepper position tracker.
// Holds event codes, register indexes, field widths and reset values.
// No dependencies.
package tasp_pkg;

	// Field widths fixed by the interface
	localparam int DEG_W  = 9;
	localparam int FUNC_W = 3;
	localparam int CDIR_W = 2;
	localparam int CIDX_W = 1;

	// Defaults for the top-level parameters
	localparam int STEPS_PER_DEG_DEF = 142;
	localparam int POSITION_BITS_DEF = 16;

	// Homing target in steps, cut to the position width where it is used.
	localparam logic [31:0] HOME_TARGET = 32'hEFFF;

	// Reset values of the axis limit registers
	localparam logic [DEG_W-1:0] AZ_LIMIT_RST = 9'd360;
	localparam logic [DEG_W-1:0] EL_LIMIT_RST = 9'd180;

	// Configuration register indexes
	localparam logic [CIDX_W-1:0] REG_AZ_LIMIT = 1'b0;
	localparam logic [CIDX_W-1:0] REG_EL_LIMIT = 1'b1;

	// Count direction codes, two's complement
	localparam logic signed [CDIR_W-1:0] CDIR_NONE = 2'sb00;
	localparam logic signed [CDIR_W-1:0] CDIR_FWD  = 2'sb01;
	localparam logic signed [CDIR_W-1:0] CDIR_REV  = 2'sb11;

	// Event codes carried in the func field
	typedef enum logic [FUNC_W-1:0] {
		FN_STEP     = 3'd0,
		FN_ENDSTOP  = 3'd1,
		FN_MOVE     = 3'd2,
		FN_STOP     = 3'd3,
		FN_STOP_ALL = 3'd4,
		FN_HOME     = 3'd5,
		FN_REPORT   = 3'd6
	} func_t;

endpackage

// ===== sv/two_axis_stepper_position_tracker.sv =====
// Two-axis stepper position tracker: top level and only module.
// Depends on tasp_pkg for event codes, register indexes and constants.
//
// Usage:
//   Event words enter on the input channel (in_valid/in_stall with func, axis and
//   target_deg). Every accepted word gives exactly one result word on the output
//   channel (out_valid/out_stall): both positions in whole degrees, the drive
//   enables, direction pins, count directions and the move_ignored flag.
//   The axis limits are written on the cfg_valid/cfg_ready port; cfg_ready is
//   always high. Write them only while no word is in flight.
//   The accepting edge loads the input register; the result register loads from
//   it when it is free or being emptied, and out_valid rises with it. Throughput
//   is one word per cycle while the receiver does not stall; the axis state is
//   updated in the same cycle as the result register loads, so the next word
//   sees it immediately.
//   The position in degrees is kept as a running quotient and remainder of
//   (position + 1) by the steps per degree, so no divider is needed.
//   Reset clears both axes to position zero with drives off and restores the
//   limits to 360 and 180 degrees.
//   When the receiver stalls, the result word holds; one further word can still
//   be taken into the input register before in_stall rises.
module two_axis_stepper_position_tracker #(
	parameter int STEPS_PER_DEG = tasp_pkg::STEPS_PER_DEG_DEF,
	parameter int POSITION_BITS = tasp_pkg::POSITION_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// Event channel
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [tasp_pkg::FUNC_W-1:0]            func,
	input  logic                                   axis,
	input  logic [tasp_pkg::DEG_W-1:0]             target_deg,
	// Result channel
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [tasp_pkg::DEG_W-1:0]             azimuth_deg,
	output logic [tasp_pkg::DEG_W-1:0]             elevation_deg,
	output logic                                   azimuth_drive,
	output logic                                   azimuth_dir_pin,
	output logic                                   elevation_drive,
	output logic                                   elevation_dir_pin,
	output logic signed [tasp_pkg::CDIR_W-1:0]     azimuth_count_dir,
	output logic signed [tasp_pkg::CDIR_W-1:0]     elevation_count_dir,
	output logic                                   move_ignored,
	// Configuration write channel
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [tasp_pkg::CIDX_W-1:0]            cfg_index,
	input  logic [tasp_pkg::DEG_W-1:0]             cfg_data
);

	localparam int POS_W = POSITION_BITS;
	localparam int QW    = POSITION_BITS + 1;
	localparam int RW    = (STEPS_PER_DEG > 1) ? $clog2(STEPS_PER_DEG) : 1;
	localparam int PW    = POSITION_BITS + tasp_pkg::DEG_W;
	localparam longint WRAP_X = longint'(1) << POSITION_BITS;

	// Quotient and remainder of (position + 1) for position zero and for the
	// largest position, used on reset, endstop and wrap.
	localparam logic [QW-1:0]    ONE_Q   = QW'(1 / STEPS_PER_DEG);
	localparam logic [RW-1:0]    ONE_R   = RW'(1 % STEPS_PER_DEG);
	localparam logic [QW-1:0]    WRAP_Q  = QW'(WRAP_X / STEPS_PER_DEG);
	localparam logic [RW-1:0]    WRAP_R  = RW'(WRAP_X % STEPS_PER_DEG);
	localparam logic [RW-1:0]    R_MAX   = RW'(STEPS_PER_DEG - 1);
	localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
	localparam logic [POS_W-1:0] HOME_P  = POS_W'(tasp_pkg::HOME_TARGET);
	localparam logic [PW-1:0]    SPD_M   = PW'(STEPS_PER_DEG);

	// Input register
	logic                        valid_s1;
	tasp_pkg::func_t             func_s1;
	logic                        axis_s1;
	logic [tasp_pkg::DEG_W-1:0]  deg_s1;

	// Limit registers
	logic [tasp_pkg::DEG_W-1:0]  az_lim_q;
	logic [tasp_pkg::DEG_W-1:0]  el_lim_q;

	// Per-axis state
	logic [POS_W-1:0]                    pos_q   [2];
	logic [POS_W-1:0]                    tgt_q   [2];
	logic signed [tasp_pkg::CDIR_W-1:0]  dir_q   [2];
	logic                                drv_q   [2];
	logic                                pin_q   [2];
	logic                                latch_q [2];
	logic [QW-1:0]                       degq_q  [2];
	logic [RW-1:0]                       degr_q  [2];

	// Next state
	logic [POS_W-1:0]                    pos_n   [2];
	logic [POS_W-1:0]                    tgt_n   [2];
	logic signed [tasp_pkg::CDIR_W-1:0]  dir_n   [2];
	logic                                drv_n   [2];
	logic                                pin_n   [2];
	logic                                latch_n [2];
	logic [QW-1:0]                       degq_n  [2];
	logic [RW-1:0]                       degr_n  [2];
	logic                                ign_n;

	logic                        out_valid_q;
	logic                        adv;
	logic                        fire;
	logic                        in_acc;
	logic [PW-1:0]               prod;
	logic [POS_W-1:0]            move_tgt;
	logic [tasp_pkg::DEG_W-1:0]  lim_sel;

	// Handshake: the input register moves on whenever the result register is
	// free or being emptied.
	assign adv       = !out_valid_q || !out_stall;
	assign fire      = valid_s1 && adv;
	assign in_stall  = valid_s1 && !adv;
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= (valid_s1 && !adv) || in_acc;
			if (adv) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// Input word capture
	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_s1 <= tasp_pkg::func_t'(func);
			axis_s1 <= axis;
			deg_s1  <= target_deg;
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			az_lim_q <= tasp_pkg::AZ_LIMIT_RST;
			el_lim_q <= tasp_pkg::EL_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tasp_pkg::REG_AZ_LIMIT: az_lim_q <= cfg_data;
				tasp_pkg::REG_EL_LIMIT: el_lim_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Target in steps for a move, shared by both axes.
	assign prod     = PW'(deg_s1) * SPD_M;
	assign move_tgt = prod[POS_W-1:0];
	assign lim_sel  = axis_s1 ? el_lim_q : az_lim_q;

	// Event decode and per-axis state update.
	always_comb begin
		logic hit;
		ign_n = 1'b0;
		for (int a = 0; a < 2; a++) begin
			hit        = (axis_s1 == 1'(a));
			pos_n[a]   = pos_q[a];
			tgt_n[a]   = tgt_q[a];
			dir_n[a]   = dir_q[a];
			drv_n[a]   = drv_q[a];
			pin_n[a]   = pin_q[a];
			latch_n[a] = latch_q[a];
			degq_n[a]  = degq_q[a];
			degr_n[a]  = degr_q[a];
			unique case (func_s1)
				tasp_pkg::FN_STEP: begin
					if (hit && drv_q[a]) begin
						if (dir_q[a] != tasp_pkg::CDIR_NONE && !dir_q[a][1]) begin
							if (pos_q[a] == POS_MAX) begin
								pos_n[a]  = '0;
								degq_n[a] = ONE_Q;
								degr_n[a] = ONE_R;
							end else begin
								pos_n[a] = pos_q[a] + POS_W'(1);
								if (degr_q[a] == R_MAX) begin
									degr_n[a] = '0;
									degq_n[a] = degq_q[a] + QW'(1);
								end else begin
									degr_n[a] = degr_q[a] + RW'(1);
								end
							end
						end else if (dir_q[a][1]) begin
							if (pos_q[a] == '0) begin
								pos_n[a]  = POS_MAX;
								degq_n[a] = WRAP_Q;
								degr_n[a] = WRAP_R;
							end else begin
								pos_n[a] = pos_q[a] - POS_W'(1);
								if (degr_q[a] == '0) begin
									degr_n[a] = R_MAX;
									degq_n[a] = degq_q[a] - QW'(1);
								end else begin
									degr_n[a] = degr_q[a] - RW'(1);
								end
							end
						end
						// Reaching the target stops the axis.
						if (pos_n[a] == tgt_q[a]) begin
							latch_n[a] = 1'b0;
							dir_n[a]   = tasp_pkg::CDIR_NONE;
							drv_n[a]   = 1'b0;
						end
					end
				end
				tasp_pkg::FN_ENDSTOP: begin
					if (hit) begin
						if (!latch_q[a]) begin
							pos_n[a]  = '0;
							degq_n[a] = ONE_Q;
							degr_n[a] = ONE_R;
							dir_n[a]  = tasp_pkg::CDIR_NONE;
							drv_n[a]  = 1'b0;
						end
						latch_n[a] = 1'b1;
					end
				end
				tasp_pkg::FN_MOVE: begin
					if (hit) begin
						if (deg_s1 > lim_sel) begin
							ign_n = 1'b1;
						end else begin
							tgt_n[a] = move_tgt;
							if (move_tgt < pos_q[a]) begin
								drv_n[a] = 1'b1;
								pin_n[a] = 1'b1;
								dir_n[a] = tasp_pkg::CDIR_REV;
							end else if (move_tgt > pos_q[a]) begin
								drv_n[a] = 1'b1;
								pin_n[a] = 1'b0;
								dir_n[a] = tasp_pkg::CDIR_FWD;
							end
						end
					end
				end
				tasp_pkg::FN_STOP: begin
					if (hit) begin
						dir_n[a] = tasp_pkg::CDIR_NONE;
						drv_n[a] = 1'b0;
					end
				end
				tasp_pkg::FN_STOP_ALL: begin
					dir_n[a]   = tasp_pkg::CDIR_NONE;
					drv_n[a]   = 1'b0;
					latch_n[a] = 1'b0;
				end
				tasp_pkg::FN_HOME: begin
					if (hit) begin
						tgt_n[a] = HOME_P;
						drv_n[a] = 1'b1;
						pin_n[a] = 1'(a);
					end
				end
				default: ;
			endcase
		end
	end

	// Axis state registers, updated as each word leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 2; a++) begin
				pos_q[a]   <= '0;
				tgt_q[a]   <= '0;
				dir_q[a]   <= tasp_pkg::CDIR_NONE;
				drv_q[a]   <= 1'b0;
				pin_q[a]   <= 1'b0;
				latch_q[a] <= 1'b0;
				degq_q[a]  <= ONE_Q;
				degr_q[a]  <= ONE_R;
			end
		end else if (fire) begin
			for (int a = 0; a < 2; a++) begin
				pos_q[a]   <= pos_n[a];
				tgt_q[a]   <= tgt_n[a];
				dir_q[a]   <= dir_n[a];
				drv_q[a]   <= drv_n[a];
				pin_q[a]   <= pin_n[a];
				latch_q[a] <= latch_n[a];
				degq_q[a]  <= degq_n[a];
				degr_q[a]  <= degr_n[a];
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (fire) begin
			azimuth_deg         <= degq_n[0][tasp_pkg::DEG_W-1:0];
			elevation_deg       <= degq_n[1][tasp_pkg::DEG_W-1:0];
			azimuth_drive       <= drv_n[0];
			azimuth_dir_pin     <= pin_n[0];
			elevation_drive     <= drv_n[1];
			elevation_dir_pin   <= pin_n[1];
			azimuth_count_dir   <= dir_n[0];
			elevation_count_dir <= dir_n[1];
			move_ignored        <= ign_n;
		end
	end

`ifndef SYNTHESIS
	// Azimuth position zero must always carry the degree count of one step.
	a_zero_pos_deg: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q[0] == '0 |-> degq_q[0] == ONE_Q && degr_q[0] == ONE_R)
		else $error("azimuth degree count out of step with position zero");

	// Every word taken from the input register produces a result word.
	a_fire_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("processed word did not reach the result register");

	// A step pulse to the azimuth axis with its drive off must leave its position alone.
	a_step_drive_off: assert property (@(posedge clk) disable iff (!arst_n)
		fire && func_s1 == tasp_pkg::FN_STEP && !axis_s1 && !drv_q[0]
		|=> $stable(pos_q[0]))
		else $error("azimuth moved on a step pulse with the drive off");
`endif

endmodule
